// ===== design/deq_pkg.sv =====
// Shared types and constants for the double-ended queue.
// Used by deq_cell, double_ended_queue and deq_checker; no dependencies.
`timescale 1ns / 1ps

package deq_pkg;

    // Storage depth and derived widths
    localparam int DEPTH   = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 5;
    localparam int CMD_W   = 2;
    localparam int STAT_W  = 2;

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((DATA_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((DATA_W + COUNT_W + 7) / 8) * 8;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_LEFT  = 2'd0,
        CMD_PUSH_RIGHT = 2'd1,
        CMD_POP_LEFT   = 2'd2,
        CMD_POP_RIGHT  = 2'd3
    } deq_cmd_t;

    typedef enum logic [STAT_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } deq_status_t;

    // One-hot operation broadcast to every cell in the row
    typedef struct packed {
        logic shift_in_left;   // push left: every entry moves one cell right
        logic shift_in_right;  // pop left: every entry moves one cell left
        logic fill_tail;       // push right: first empty cell takes the value
        logic drop_tail;       // pop right: last occupied cell empties
    } deq_op_t;

endpackage

// ===== design/double_ended_queue.sv =====
// Top level of the double-ended queue: command decode, cell row, result register.
// Depends on deq_pkg and deq_cell.
`timescale 1ns / 1ps

// Bounded double-ended queue of DEPTH signed 32-bit values, kept in a row of
// cells with the leftmost element always in cell 0. Each command beat (push
// left, push right, pop left, pop right) updates the whole cell row together and
// yields one registered result beat in the next cycle, so the block takes one
// command per cycle as long as the result channel is not held by back-pressure. A new
// command is taken while the result register is empty or being drained in the
// same cycle. A pop on an empty queue reports status empty, a push on a full
// queue reports status full and is dropped; neither changes the contents.
module double_ended_queue (
    input  logic                            clk,
    input  logic                            rst_n,
    // Command channel
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [deq_pkg::S_TDATA_W-1:0]   s_tdata,   // [31:0] push_value
    input  logic [deq_pkg::CMD_W-1:0]       s_tuser,   // [1:0] cmd
    // Result channel
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [deq_pkg::M_TDATA_W-1:0]   m_tdata,   // [31:0] pop_value, [36:32] count
    output logic [deq_pkg::STAT_W-1:0]      m_tuser    // [1:0] status
);

    localparam int PAD_W = deq_pkg::M_TDATA_W - deq_pkg::DATA_W - deq_pkg::COUNT_W;

    logic                                 accept;
    logic                                 full;
    logic                                 empty;
    deq_pkg::deq_cmd_t                    cmd;
    logic signed [deq_pkg::DATA_W-1:0]    push_value;
    deq_pkg::deq_op_t                     op;

    logic signed [deq_pkg::DATA_W-1:0]    cell_data  [deq_pkg::DEPTH];
    logic                                 cell_valid [deq_pkg::DEPTH];
    logic signed [deq_pkg::DATA_W-1:0]    tail_data;

    logic [deq_pkg::CNT_W-1:0]            count_reg;
    logic [deq_pkg::CNT_W-1:0]            count_next;
    logic                                 out_valid_reg;
    logic signed [deq_pkg::DATA_W-1:0]    pop_value_reg;
    logic signed [deq_pkg::DATA_W-1:0]    pop_value_next;
    deq_pkg::deq_status_t                 status_reg;
    deq_pkg::deq_status_t                 status_next;

    assign cmd        = deq_pkg::deq_cmd_t'(s_tuser);
    assign push_value = s_tdata[deq_pkg::DATA_W-1:0];
    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign full       = (count_reg == deq_pkg::CNT_W'(deq_pkg::DEPTH));
    assign empty      = (count_reg == '0);

    // Build the cell row; cell 0 holds the leftmost element
    for (genvar i = 0; i < deq_pkg::DEPTH; i++)
    begin : g_cell
        logic signed [deq_pkg::DATA_W-1:0] left_data;
        logic                              left_valid;
        logic signed [deq_pkg::DATA_W-1:0] right_data;
        logic                              right_valid;

        if (i == 0)
        begin : g_first
            assign left_data  = push_value;
            assign left_valid = 1'b1;
        end
        else
        begin : g_inner_left
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_valid[i-1];
        end

        if (i == deq_pkg::DEPTH - 1)
        begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner_right
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_valid[i+1];
        end

        deq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .op          (op),
            .push_value  (push_value),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .valid       (cell_valid[i])
        );
    end

    // Select the value in the last occupied cell
    always_comb
    begin
        tail_data = '0;
        for (int i = 0; i < deq_pkg::DEPTH; i++)
        begin
            if (cell_valid[i] && (i == deq_pkg::DEPTH - 1 || !cell_valid[(i + 1) % deq_pkg::DEPTH]))
            begin
                tail_data = tail_data | cell_data[i];
            end
        end
    end

    // Decode the command into a row operation and a result
    always_comb
    begin
        op             = '0;
        count_next     = count_reg;
        pop_value_next = '0;
        status_next    = deq_pkg::STATUS_OK;
        unique case (cmd)
            deq_pkg::CMD_PUSH_LEFT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    op.shift_in_left = accept;
                    count_next       = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_PUSH_RIGHT:
            begin
                if (full)
                begin
                    status_next = deq_pkg::STATUS_FULL;
                end
                else
                begin
                    op.fill_tail = accept;
                    count_next   = count_reg + 1'b1;
                end
            end
            deq_pkg::CMD_POP_LEFT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    op.shift_in_right = accept;
                    count_next        = count_reg - 1'b1;
                    pop_value_next    = cell_data[0];
                end
            end
            deq_pkg::CMD_POP_RIGHT:
            begin
                if (empty)
                begin
                    status_next = deq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    op.drop_tail   = accept;
                    count_next     = count_reg - 1'b1;
                    pop_value_next = tail_data;
                end
            end
            default:
            begin
                op = '0;
            end
        endcase
    end

    // Advance the count and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Load the result beat
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pop_value_reg <= pop_value_next;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, deq_pkg::COUNT_W'(count_reg), pop_value_reg};
    assign m_tuser  = status_reg;

endmodule

// ===== design/deq_cell.sv =====
// One storage cell of the queue row: a value and an occupied flag.
// Depends on deq_pkg; instanced DEPTH times by double_ended_queue.
`timescale 1ns / 1ps

module deq_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  deq_pkg::deq_op_t                  op,
    input  logic signed [deq_pkg::DATA_W-1:0] push_value,
    input  logic signed [deq_pkg::DATA_W-1:0] left_data,
    input  logic                              left_valid,
    input  logic signed [deq_pkg::DATA_W-1:0] right_data,
    input  logic                              right_valid,
    output logic signed [deq_pkg::DATA_W-1:0] data,
    output logic                              valid
);

    logic signed [deq_pkg::DATA_W-1:0] data_reg;
    logic signed [deq_pkg::DATA_W-1:0] data_next;
    logic                              valid_reg;
    logic                              valid_next;

    // Pick the next contents from the neighbors or the pushed value
    always_comb
    begin
        data_next  = data_reg;
        valid_next = valid_reg;
        priority if (op.shift_in_left)
        begin
            data_next  = left_data;
            valid_next = left_valid;
        end
        else if (op.shift_in_right)
        begin
            data_next  = right_data;
            valid_next = right_valid;
        end
        else if (op.fill_tail)
        begin
            if (!valid_reg && left_valid)
            begin
                data_next  = push_value;
                valid_next = 1'b1;
            end
        end
        else if (op.drop_tail)
        begin
            if (valid_reg && !right_valid)
            begin
                valid_next = 1'b0;
            end
        end
    end

    // Hold the occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the value
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign valid = valid_reg;

endmodule

// ===== design/deq_checker.sv =====
// Port-level checks for double_ended_queue, attached by bind.
// Depends on deq_pkg.
`timescale 1ns / 1ps

module deq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [deq_pkg::STAT_W-1:0]    m_tuser
);

    localparam int CNT_LO = deq_pkg::DATA_W;
    localparam int CNT_HI = deq_pkg::DATA_W + deq_pkg::COUNT_W - 1;

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every accepted command shows a result on the next cycle
    a_one_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted command produced no result");

    // Commands are taken whenever the result register is free
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("command stalled with empty result register");

    // An empty pop reports zero count and zero value
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == deq_pkg::STATUS_EMPTY |->
            m_tdata[CNT_HI:CNT_LO] == '0 && m_tdata[deq_pkg::DATA_W-1:0] == '0)
        else $error("empty pop reported a value or nonzero count");

    // A dropped push reports a full queue
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == deq_pkg::STATUS_FULL |->
            m_tdata[CNT_HI:CNT_LO] == deq_pkg::COUNT_W'(deq_pkg::DEPTH))
        else $error("full status with count below depth");

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
